FILE: rtl/mlm_pkg.sv
// shared constants and codes of the multi-list membership table
// no dependencies

package mlm_pkg;

  localparam int MAX_ARCS = 1024;
  localparam int IDX_W    = $clog2(MAX_ARCS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int SEED_W   = 32;
  localparam int FLAG_W   = 4;

  localparam logic [IDX_W-1:0] NO_SLOT = '1;

  // flag bit positions, the list codes match the first three
  localparam int F_ACTIVE     = 0;
  localparam int F_VALID      = 1;
  localparam int F_RESTORABLE = 2;
  localparam int F_DIRTY      = 3;

  localparam logic [1:0] LIST_ACTIVE     = 2'd0;
  localparam logic [1:0] LIST_VALID      = 2'd1;
  localparam logic [1:0] LIST_RESTORABLE = 2'd2;

  localparam logic [2:0] OP_ADD_ACTIVE     = 3'd0;
  localparam logic [2:0] OP_REM_ACTIVE     = 3'd1;
  localparam logic [2:0] OP_ADD_VALID      = 3'd2;
  localparam logic [2:0] OP_REM_VALID      = 3'd3;
  localparam logic [2:0] OP_ADD_RESTORABLE = 3'd4;
  localparam logic [2:0] OP_REM_RESTORABLE = 3'd5;
  localparam logic [2:0] OP_QUERY          = 3'd6;
  localparam logic [2:0] OP_READ_SLOT      = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_NO_SLOT = 2'd2;

endpackage

FILE: rtl/mlm_in_if.sv
// request and response channel interfaces of the membership table
// depends on mlm_pkg

interface mlm_in_if import mlm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [IDX_W-1:0]  arc_id;
  logic [SEED_W-1:0] seed_word;
  logic [1:0]        list_pick;
  logic [IDX_W-1:0]  slot_pos;
  modport source (output valid, op, arc_id, seed_word, list_pick, slot_pos, input ready);
  modport sink (input valid, op, arc_id, seed_word, list_pick, slot_pos, output ready);
endinterface

interface mlm_out_if import mlm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [FLAG_W-1:0] flags_out;
  logic [SEED_W-1:0] seed_out;
  logic [IDX_W-1:0]  slot_arc;
  logic [CNT_W-1:0]  active_count;
  logic [CNT_W-1:0]  valid_count;
  logic [CNT_W-1:0]  restorable_count;
  modport source (output valid, status, flags_out, seed_out, slot_arc, active_count,
                  valid_count, restorable_count, input ready);
  modport sink (input valid, status, flags_out, seed_out, slot_arc, active_count,
                valid_count, restorable_count, output ready);
endinterface

FILE: rtl/multi_list_membership_table.sv
// top level of the multi-list membership table: sequencer, counts, rams
// depends on mlm_pkg, mlm_in_if / mlm_out_if and mlm_ram
//
// usage
// - req channel carries one command word (op, arc_id, seed_word, list_pick,
//   slot_pos); rsp channel returns exactly one result word per command
// - a word moves on a rising edge with valid and ready both high
// - three dense lists (active, valid, restorable) live in rams; a remove
//   swaps the list tail into the freed slot, so every list step is constant
// - every command reads the rams and then writes its result; a remove of a
//   member first runs one swap step on its list, and remove valid runs one
//   swap step per list the arc leaves, in the order active, restorable, valid
//   the swap step is read of back-index and tail, write of slot and tail
//   back-index, write of the freed back-index, all through one write port
//   per ram; one command is in flight at a time
// - after reset the flag ram is swept to zero over all MAX_ARCS (1024) entries,
//   with req.ready low; counts reset to zero at once
// - the result sits in an output register; a new command is taken while it
//   waits, and the next result waits in its last state until rsp is free

module multi_list_membership_table import mlm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mlm_in_if.sink    req,
  mlm_out_if.source rsp
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_R1   = 3'd3;
  localparam logic [2:0] S_R2   = 3'd4;
  localparam logic [2:0] S_R3   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state;
  logic [IDX_W-1:0]  clr_addr;
  logic [2:0]        op_q;
  logic [IDX_W-1:0]  arc_q;
  logic [SEED_W-1:0] seed_in_q;
  logic [1:0]        pick_q;
  logic [IDX_W-1:0]  pos_q;
  logic [1:0]        lst;           // list the current step works on
  logic [FLAG_W-1:0] flags_q;
  logic [SEED_W-1:0] seed_q;
  logic [1:0]        status_q;
  logic [IDX_W-1:0]  slot_q;
  logic [CNT_W-1:0]  cnt [3];

  // result register
  logic              out_valid;
  logic [1:0]        o_status;
  logic [FLAG_W-1:0] o_flags;
  logic [SEED_W-1:0] o_seed;
  logic [IDX_W-1:0]  o_slot;
  logic [CNT_W-1:0]  o_cnt [3];

  // ram ports
  logic              flg_we;
  logic [IDX_W-1:0]  flg_waddr, flg_raddr;
  logic [FLAG_W-1:0] flg_wdata, flg_rdata;
  logic              seed_we;
  logic [SEED_W-1:0] seed_rdata;
  logic              ent_we_any;
  logic [2:0]        ent_we;
  logic [IDX_W-1:0]  ent_waddr, ent_wdata, ent_raddr;
  logic [IDX_W-1:0]  ent_rdata [3];
  logic              idx_we_any;
  logic [1:0]        idx_we;
  logic [IDX_W-1:0]  idx_waddr, idx_wdata;
  logic [IDX_W-1:0]  idx_rdata [2];

  // decode helpers
  logic [CNT_W-1:0]  cnt_sel, cnt_dec, cnt_pick;
  logic              is_add, is_rem, member, add_ok;
  logic [IDX_W-1:0]  cur, tail, ent_pick;
  logic              out_free;

  always_comb begin
    case (lst)
      LIST_ACTIVE:     cnt_sel = cnt[0];
      LIST_VALID:      cnt_sel = cnt[1];
      LIST_RESTORABLE: cnt_sel = cnt[2];
      default:         cnt_sel = '0;
    endcase
    case (lst)
      LIST_VALID:      tail = ent_rdata[1];
      LIST_RESTORABLE: tail = ent_rdata[2];
      default:         tail = ent_rdata[0];
    endcase
    case (pick_q)
      LIST_ACTIVE:     begin cnt_pick = cnt[0]; ent_pick = ent_rdata[0]; end
      LIST_VALID:      begin cnt_pick = cnt[1]; ent_pick = ent_rdata[1]; end
      LIST_RESTORABLE: begin cnt_pick = cnt[2]; ent_pick = ent_rdata[2]; end
      default:         begin cnt_pick = '0;     ent_pick = '0;           end
    endcase
  end

  assign cnt_dec  = cnt_sel - CNT_W'(1);
  assign cur      = (lst == LIST_VALID) ? idx_rdata[1] : idx_rdata[0];
  assign is_add   = (op_q inside {OP_ADD_ACTIVE, OP_ADD_VALID, OP_ADD_RESTORABLE});
  assign is_rem   = (op_q inside {OP_REM_ACTIVE, OP_REM_VALID, OP_REM_RESTORABLE});
  assign member   = flg_rdata[lst];
  assign add_ok   = (state == S_RD) && is_add && !member;
  assign out_free = !out_valid || rsp.ready;

  // flag ram: swept on reset, written back at the end of each command
  assign flg_raddr = (state == S_IDLE) ? req.arc_id : arc_q;
  assign flg_we    = (state == S_CLR) || (state == S_FIN);
  assign flg_waddr = (state == S_CLR) ? clr_addr : arc_q;
  assign flg_wdata = (state == S_CLR) ? '0 : flags_q;

  assign seed_we = add_ok && (lst == LIST_ACTIVE);

  // list entry rams, all read at the same address
  assign ent_raddr = (state == S_IDLE) ? req.slot_pos : cnt_dec[IDX_W-1:0];
  always_comb begin
    ent_we_any = 1'b0;
    ent_waddr  = cnt_sel[IDX_W-1:0];
    ent_wdata  = arc_q;
    idx_we_any = 1'b0;
    idx_waddr  = arc_q;
    idx_wdata  = cnt_sel[IDX_W-1:0];
    case (state)
      S_RD: begin
        // append at the tail unless the list is already full
        ent_we_any = add_ok && !cnt_sel[IDX_W];
        idx_we_any = add_ok && !cnt_sel[IDX_W];
      end
      S_R2: begin
        ent_we_any = 1'b1;
        ent_waddr  = cur;
        ent_wdata  = tail;
        idx_we_any = 1'b1;
        idx_waddr  = tail;
        idx_wdata  = cur;
      end
      S_R3: begin
        idx_we_any = 1'b1;
        idx_wdata  = NO_SLOT;
      end
      default: begin
      end
    endcase
  end

  assign ent_we[0] = ent_we_any && (lst == LIST_ACTIVE);
  assign ent_we[1] = ent_we_any && (lst == LIST_VALID);
  assign ent_we[2] = ent_we_any && (lst == LIST_RESTORABLE);
  // active and restorable share one back-index ram
  assign idx_we[0] = idx_we_any && (lst != LIST_VALID);
  assign idx_we[1] = idx_we_any && (lst == LIST_VALID);

  mlm_ram #(.WIDTH(FLAG_W), .DEPTH(MAX_ARCS)) u_flags (
    .clk, .we(flg_we), .waddr(flg_waddr), .wdata(flg_wdata),
    .raddr(flg_raddr), .rdata(flg_rdata)
  );

  mlm_ram #(.WIDTH(SEED_W), .DEPTH(MAX_ARCS)) u_seed (
    .clk, .we(seed_we), .waddr(arc_q), .wdata(seed_in_q),
    .raddr(flg_raddr), .rdata(seed_rdata)
  );

  for (genvar g = 0; g < 3; g++) begin : g_ent
    mlm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ARCS)) u_ent (
      .clk, .we(ent_we[g]), .waddr(ent_waddr), .wdata(ent_wdata),
      .raddr(ent_raddr), .rdata(ent_rdata[g])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_idx
    mlm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ARCS)) u_idx (
      .clk, .we(idx_we[g]), .waddr(idx_waddr), .wdata(idx_wdata),
      .raddr(arc_q), .rdata(idx_rdata[g])
    );
  end

  assign req.ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      cnt[2]    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(MAX_ARCS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op_q      <= req.op;
            arc_q     <= req.arc_id;
            seed_in_q <= req.seed_word;
            pick_q    <= req.list_pick;
            pos_q     <= req.slot_pos;
            lst       <= req.op[2:1];
            state     <= S_RD;
          end
        end
        S_RD: begin
          flags_q  <= flg_rdata;
          seed_q   <= seed_rdata;
          status_q <= ST_OK;
          slot_q   <= '0;
          state    <= S_FIN;
          if (op_q == OP_READ_SLOT) begin
            if (pick_q != 2'd3 && {1'b0, pos_q} < cnt_pick) begin
              slot_q <= ent_pick;
            end else begin
              status_q <= ST_NO_SLOT;
            end
          end else if (is_add) begin
            if (member) begin
              status_q <= ST_REFUSED;
            end else begin
              flags_q <= flg_rdata | (FLAG_W'(1) << lst)
                         | ((lst == LIST_ACTIVE) ? FLAG_W'(1 << F_DIRTY) : '0);
              if (lst == LIST_ACTIVE) begin
                seed_q <= seed_in_q;
              end
              if (!cnt_sel[IDX_W]) begin
                cnt[lst] <= cnt_sel + CNT_W'(1);
              end
            end
          end else if (is_rem) begin
            if (!member) begin
              status_q <= ST_REFUSED;
            end else begin
              state <= S_R1;
              // leaving valid drops the arc from active, then restorable, then valid
              if (op_q == OP_REM_VALID) begin
                if (flg_rdata[F_ACTIVE]) begin
                  lst <= LIST_ACTIVE;
                end else if (flg_rdata[F_RESTORABLE]) begin
                  lst <= LIST_RESTORABLE;
                end else begin
                  lst <= LIST_VALID;
                end
              end
            end
          end
        end
        S_R1: begin
          // back-index and tail entry are being read
          cnt[lst] <= cnt_dec;
          state    <= S_R2;
        end
        S_R2: begin
          state <= S_R3;
        end
        S_R3: begin
          flags_q[lst] <= 1'b0;
          state        <= S_FIN;
          if (op_q == OP_REM_VALID) begin
            if (lst == LIST_ACTIVE && flags_q[F_RESTORABLE]) begin
              lst   <= LIST_RESTORABLE;
              state <= S_R1;
            end else if (lst != LIST_VALID) begin
              lst   <= LIST_VALID;
              state <= S_R1;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      o_status <= status_q;
      o_flags  <= flags_q;
      o_seed   <= flags_q[F_DIRTY] ? seed_q : '0;
      o_slot   <= slot_q;
      o_cnt[0] <= cnt[0];
      o_cnt[1] <= cnt[1];
      o_cnt[2] <= cnt[2];
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = o_status;
  assign rsp.flags_out        = o_flags;
  assign rsp.seed_out         = o_seed;
  assign rsp.slot_arc         = o_slot;
  assign rsp.active_count     = o_cnt[0];
  assign rsp.valid_count      = o_cnt[1];
  assign rsp.restorable_count = o_cnt[2];

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= CNT_W'(MAX_ARCS) && cnt[1] <= CNT_W'(MAX_ARCS)
    && cnt[2] <= CNT_W'(MAX_ARCS))
    else $error("list count beyond table size");

  a_accept_to_rd: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == S_RD)
    else $error("accepted command not followed by ram read");

  a_one_list_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ent_we))
    else $error("more than one list ram written");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == S_R1 |=> cnt[lst] == $past(cnt_sel) - CNT_W'(1))
    else $error("remove step did not shrink its list");

endmodule

FILE: rtl/mlm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module mlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
